// File: hw/rtl/assert_macros.svh
// Assertion macros used by the scanner top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/sm4ks_pkg.sv
// Package for the SM4 round key scanner: S-box, FK/CK constants, key transform.
// No dependencies.
`default_nettype none
package sm4ks_pkg;
   localparam int WindowLength = 24;
   localparam int DefaultAddressWidth = 64;
   localparam int QueueDepth = 4;

   typedef logic [7:0] sbox_table_type [256];
   localparam sbox_table_type Sbox = '{
 8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
 8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
 8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
 8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
 8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
 8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
 8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
 8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
 8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
 8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
 8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
 8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
 8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
 8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
 8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
 8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};

   localparam logic [31:0] Fk0 = 32'ha3b1bac6;
   localparam logic [31:0] Fk1 = 32'h56aa3350;
   localparam logic [31:0] Fk2 = 32'h677d9197;
   localparam logic [31:0] Fk3 = 32'hb27022dc;
   localparam logic [31:0] Ck0 = 32'h00070e15;
   localparam logic [31:0] Ck1 = 32'h1c232a31;
   localparam logic [31:0] Ck2 = 32'h383f464d;
   localparam logic [31:0] Ck3 = 32'h545b6269;
   localparam logic [31:0] Ck4 = 32'h70777e85;
   localparam logic [31:0] Ck5 = 32'h8c939aa1;

   // S-box on each byte, then L'
   function automatic logic [31:0] key_transform(input logic [31:0] x);
      logic [31:0] b;
      b = {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   typedef struct packed {
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      logic [63:0] start;
   } cand_type;
endpackage
`default_nettype wire

// File: hw/rtl/sm4ks_front.sv
// Front: sliding window, skip control and hit test; emits candidate windows.
// Depends on sm4ks_pkg.
`default_nettype none
module sm4ks_front #(
   parameter int ADDRESS_WIDTH = sm4ks_pkg::DefaultAddressWidth
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       take,
   input  wire [7:0]                 data_byte,
   input  wire                       starts_buffer,
   input  wire [ADDRESS_WIDTH-1:0]   base_address,
   output logic                      cand_valid,
   output sm4ks_pkg::cand_type       cand
);
   import sm4ks_pkg::*;
   localparam int Wb = 8 * WindowLength;

   logic [Wb-1:0] win_ff, win_in;
   logic [4:0] fill_ff, fill_in, skip_ff, skip_in;
   logic [63:0] offs_ff, offs_in;
   logic [ADDRESS_WIDTH-1:0] base_ff, base_in;
   // stage 2 registers (test)
   logic s2_ff, s2_in;
   logic [Wb-1:0] w2_ff;
   logic [63:0] st_ff;
   logic [31:0] w0, w1, w2, w3, w4, w5;
   logic hit;

   always_comb begin
      logic [Wb-1:0] wbase;
      logic [4:0] fbase;
      wbase = win_ff; fbase = fill_ff;
      skip_in = skip_ff; offs_in = offs_ff; base_in = base_ff;
      s2_in = 1'b0;
      if (starts_buffer) begin
         wbase = '0; fbase = '0; skip_in = '0; offs_in = '0;
         base_in = base_address;
      end else if (fill_ff != 5'd0) begin
         offs_in = offs_ff + 64'd1;
      end
      win_in = {data_byte, wbase[Wb-1:8]};
      fill_in = (fbase < 5'(WindowLength)) ? fbase + 5'd1 : fbase;
      if (fill_in == 5'(WindowLength)) begin
         if (skip_in != 5'd0) skip_in = skip_in - 5'd1;
         else s2_in = 1'b1;
      end
      // a hit on the previous window lands now; this byte's window is then
      // the first one skipped, unless the byte starts a new buffer
      if (s2_ff && hit && !starts_buffer) begin
         skip_in = 5'(WindowLength - 1);
         s2_in = 1'b0;
      end
      if (!take) begin
         win_in = win_ff; fill_in = fill_ff; skip_in = (s2_ff && hit) ?
            5'(WindowLength) : skip_ff;
         offs_in = offs_ff; base_in = base_ff; s2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0; fill_ff <= '0; skip_ff <= '0; offs_ff <= '0; base_ff <= '0;
         s2_ff <= 1'b0;
      end else begin
         win_ff <= win_in; fill_ff <= fill_in; skip_ff <= skip_in;
         offs_ff <= offs_in; base_ff <= base_in; s2_ff <= s2_in;
      end
      w2_ff <= win_in;
      st_ff <= 64'(base_in) + offs_in - 64'(WindowLength - 1);
   end

   assign w0 = w2_ff[31:0];
   assign w1 = w2_ff[63:32];
   assign w2 = w2_ff[95:64];
   assign w3 = w2_ff[127:96];
   assign w4 = w2_ff[159:128];
   assign w5 = w2_ff[191:160];
   assign hit = (w4 == (w0 ^ key_transform(w1 ^ w2 ^ w3 ^ Ck4)))
             && (w5 == (w1 ^ key_transform(w2 ^ w3 ^ w4 ^ Ck5)));
   assign cand_valid = s2_ff && hit;
   assign cand = '{w0: w0, w1: w1, w2: w2, w3: w3, start: st_ff};
endmodule
`default_nettype wire

// File: hw/rtl/sm4ks_queue.sv
// Small FIFO between front and back.
// Depends on sm4ks_pkg.
`default_nettype none
module sm4ks_queue #(
   parameter int DEPTH = sm4ks_pkg::QueueDepth
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr,
   input  sm4ks_pkg::cand_type   wdata,
   input  wire                   rd,
   output logic                  not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output sm4ks_pkg::cand_type   rdata
);
   import sm4ks_pkg::*;
   localparam int Aw = $clog2(DEPTH);
   cand_type mem_ff [DEPTH];
   logic [Aw-1:0] wp_ff, rp_ff;
   logic [$clog2(DEPTH+1)-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= (wp_ff == Aw'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (rd) rp_ff <= (rp_ff == Aw'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
      end
      if (wr) mem_ff[wp_ff] <= wdata;
   end
   assign not_empty = cnt_ff != '0;
   assign count = cnt_ff;
   assign rdata = mem_ff[rp_ff];
endmodule
`default_nettype wire

// File: hw/rtl/sm4ks_back.sv
// Back: inverts four key-schedule rounds, one per cycle, then holds the result.
// Depends on sm4ks_pkg.
`default_nettype none
module sm4ks_back #(
   parameter int ADDRESS_WIDTH = sm4ks_pkg::DefaultAddressWidth
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       q_valid,
   input  sm4ks_pkg::cand_type       q_data,
   output logic                      q_take,
   input  wire                       pop,
   output logic                      empty,
   output logic [ADDRESS_WIDTH-1:0]  hit_address,
   output logic [31:0]               k0,
   output logic [31:0]               k1,
   output logic [31:0]               k2,
   output logic [31:0]               k3
);
   import sm4ks_pkg::*;
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StRun  = 2'd1;
   localparam logic [1:0] StDone = 2'd2;

   logic [1:0] st_ff, st_in;
   logic [1:0] rnd_ff;
   // shift state: a,b,c,d where the next recovered word = d ^ T(a^b^c^ck)
   logic [31:0] a_ff, b_ff, c_ff, d_ff, m3_ff, m2_ff, m1_ff, m0_ff;
   logic [63:0] st_addr_ff;
   logic [31:0] ck, nw;

   always_comb begin
      unique case (rnd_ff)
         2'd0: ck = Ck3;
         2'd1: ck = Ck2;
         2'd2: ck = Ck1;
         default: ck = Ck0;
      endcase
   end
   assign nw = d_ff ^ key_transform(a_ff ^ b_ff ^ c_ff ^ ck);
   assign q_take = q_valid && (st_ff == StIdle);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         StIdle: if (q_valid) st_in = StRun;
         StRun: if (rnd_ff == 2'd3) st_in = StDone;
         StDone: if (pop) st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle; rnd_ff <= '0;
      end else begin
         st_ff <= st_in;
         rnd_ff <= (st_ff == StRun) ? rnd_ff + 2'd1 : 2'd0;
      end
      if (q_take) begin
         // round 3: w3 ^ T(w2^w1^w0^CK3)
         a_ff <= q_data.w2; b_ff <= q_data.w1; c_ff <= q_data.w0; d_ff <= q_data.w3;
         st_addr_ff <= q_data.start;
      end else if (st_ff == StRun) begin
         unique case (rnd_ff)
            2'd0: begin m3_ff <= nw; a_ff <= b_ff; b_ff <= c_ff; c_ff <= nw;
               d_ff <= a_ff; end
            2'd1: begin m2_ff <= nw; a_ff <= b_ff; b_ff <= c_ff; c_ff <= nw;
               d_ff <= a_ff; end
            2'd2: begin m1_ff <= nw; a_ff <= b_ff; b_ff <= c_ff; c_ff <= nw;
               d_ff <= a_ff; end
            default: m0_ff <= nw;
         endcase
      end
   end

   assign empty = st_ff != StDone;
   assign hit_address = st_addr_ff[ADDRESS_WIDTH-1:0];
   assign k0 = m0_ff ^ Fk0;
   assign k1 = m1_ff ^ Fk1;
   assign k2 = m2_ff ^ Fk2;
   assign k3 = m3_ff ^ Fk3;
endmodule
`default_nettype wire

// File: hw/rtl/sm4_round_key_scanner.sv
// SM4 round key scanner top level.
// Uses sm4ks_pkg, sm4ks_front, sm4ks_queue, sm4ks_back, assert_macros.svh.
//
// Use: push one byte of a memory image per item on req_data_byte; raise
// req_starts_buffer with the first byte of a buffer and its address on
// req_base_address. Whenever a 24-byte window is a valid SM4 key-schedule
// fragment (round keys 4 and 5 follow from 0..3) and starts at least 25
// bytes after the last hit window in its buffer, one item comes out on the
// rsp_ side: the window's start address and the recovered master key.
// Throughput: one byte per cycle while full is low. Window test is a
// two-stage pipeline in the front; the back takes a candidate and inverts
// four rounds with one shared key transform. Within a buffer hits are at
// least 25 bytes apart, so the back keeps up. full rises only when the queue
// between front and back holds two or more candidates, which happens only
// while the receiver stalls with results pending.
// Reset (synchronous, active high) empties window, queue and result.
// While pop stays low a finished result holds on the rsp_ ports.
`default_nettype none
`include "assert_macros.svh"
module sm4_round_key_scanner #(
   parameter int ADDRESS_WIDTH = sm4ks_pkg::DefaultAddressWidth
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   output logic                      full,
   input  wire [7:0]                 req_data_byte,
   input  wire                       req_starts_buffer,
   input  wire [ADDRESS_WIDTH-1:0]   req_base_address,
   output logic                      empty,
   input  wire                       pop,
   output logic [ADDRESS_WIDTH-1:0]  rsp_hit_address,
   output logic [31:0]               rsp_key_word_zero,
   output logic [31:0]               rsp_key_word_one,
   output logic [31:0]               rsp_key_word_two,
   output logic [31:0]               rsp_key_word_three
);
   import sm4ks_pkg::*;
   localparam int Cw = $clog2(QueueDepth + 1);

   logic take, cand_valid, q_ne, q_take;
   cand_type cand, q_data;
   logic [Cw-1:0] q_count;

   // two slots kept free for windows already in the test pipeline
   assign full = q_count >= Cw'(QueueDepth - 2);
   assign take = push && !full;

   sm4ks_front #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_front (
      .clock, .reset, .take,
      .data_byte(req_data_byte), .starts_buffer(req_starts_buffer),
      .base_address(req_base_address), .cand_valid, .cand);

   sm4ks_queue #(.DEPTH(QueueDepth)) u_queue (
      .clock, .reset, .wr(cand_valid), .wdata(cand), .rd(q_take),
      .not_empty(q_ne), .count(q_count), .rdata(q_data));

   sm4ks_back #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_back (
      .clock, .reset, .q_valid(q_ne), .q_data, .q_take, .pop, .empty,
      .hit_address(rsp_hit_address), .k0(rsp_key_word_zero),
      .k1(rsp_key_word_one), .k2(rsp_key_word_two), .k3(rsp_key_word_three));

   `ASSERT_IMPL(a_no_overflow, clock, reset, q_count == Cw'(QueueDepth), !cand_valid)
   `ASSERT_NEXT(a_rsp_holds, clock, reset, !empty && !pop, !empty)
   `ASSERT_IMPL(a_take_needs_data, clock, reset, q_take, q_ne)
endmodule
`default_nettype wire

// File: tb/tb_sm4_round_key_scanner.sv
// Self-checking bench for the SM4 round key scanner: byte stream in, recovered keys out.
// Depends on sm4ks_pkg (window length, S-box table, FK words) and the scanner RTL.
`timescale 1ns / 1ps
module tb_sm4_round_key_scanner;
   import sm4ks_pkg::*;

   localparam int AddrWidth = DefaultAddressWidth;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic [63:0] addr;
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] k2;
      logic [31:0] k3;
   } key_hit_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic [63:0] base;
   } scan_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic [7:0] req_data_byte = '0;
   logic req_starts_buffer = 1'b0;
   logic [AddrWidth-1:0] req_base_address = '0;
   logic full, empty;
   logic [AddrWidth-1:0] rsp_hit_address;
   logic [31:0] rsp_key_word_zero, rsp_key_word_one, rsp_key_word_two, rsp_key_word_three;

   always #6 clock = ~clock;

   sm4_round_key_scanner dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_starts_buffer(req_starts_buffer),
      .req_base_address(req_base_address), .empty(empty), .pop(pop),
      .rsp_hit_address(rsp_hit_address), .rsp_key_word_zero(rsp_key_word_zero),
      .rsp_key_word_one(rsp_key_word_one), .rsp_key_word_two(rsp_key_word_two),
      .rsp_key_word_three(rsp_key_word_three)
   );

   // scanner state mirrored in the bench
   logic [7:0]  win [WindowLength];
   int          win_fill;
   int          skip_left;
   logic [63:0] buf_offset;
   logic [63:0] buf_base;

   key_hit_type pending_keys [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          stim_done = 0;

   // directed rows carry an optional typed-in expected key
   scan_byte_type plan [$];
   bit            plan_has_exp [$];
   key_hit_type   plan_exp [$];

   function automatic logic [31:0] ck_word(input int i);
      logic [31:0] v;
      v = '0;
      for (int j = 0; j < 4; j++) v = {v[23:0], 8'((4 * i + j) * 7)};
      return v;
   endfunction

   // byte-wise S-box then L' = x ^ rotl13 ^ rotl23
   function automatic logic [31:0] tau_lprime(input logic [31:0] x);
      logic [31:0] b;
      b = {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   function automatic logic [31:0] win_word(input int k);
      return {win[4*k+3], win[4*k+2], win[4*k+1], win[4*k]};
   endfunction

   // advance the mirror by one byte; returns 1 and the key on a hit
   function automatic bit scan_step(input scan_byte_type it, output key_hit_type hit);
      logic [31:0] w [6];
      logic [31:0] m0, m1, m2, m3;
      hit = '0;
      if (it.first) begin
         foreach (win[i]) win[i] = '0;
         win_fill = 0;
         skip_left = 0;
         buf_offset = '0;
         buf_base = it.base;
      end else if (win_fill != 0) begin
         buf_offset++;
      end
      for (int i = 0; i < WindowLength - 1; i++) win[i] = win[i+1];
      win[WindowLength-1] = it.data;
      if (win_fill < WindowLength) win_fill++;
      if (win_fill < WindowLength) return 0;
      if (skip_left != 0) begin
         skip_left--;
         return 0;
      end
      for (int k = 0; k < 6; k++) w[k] = win_word(k);
      if (w[4] != (w[0] ^ tau_lprime(w[1] ^ w[2] ^ w[3] ^ ck_word(4)))) return 0;
      if (w[5] != (w[1] ^ tau_lprime(w[2] ^ w[3] ^ w[4] ^ ck_word(5)))) return 0;
      m3 = w[3] ^ tau_lprime(w[2] ^ w[1] ^ w[0] ^ ck_word(3));
      m2 = w[2] ^ tau_lprime(w[1] ^ w[0] ^ m3 ^ ck_word(2));
      m1 = w[1] ^ tau_lprime(w[0] ^ m3 ^ m2 ^ ck_word(1));
      m0 = w[0] ^ tau_lprime(m3 ^ m2 ^ m1 ^ ck_word(0));
      hit.addr = buf_base + buf_offset - 64'(WindowLength - 1);
      hit.k0 = Fk0 ^ m0;
      hit.k1 = Fk1 ^ m1;
      hit.k2 = Fk2 ^ m2;
      hit.k3 = Fk3 ^ m3;
      skip_left = WindowLength;
      return 1;
   endfunction

   // forward key schedule: master key -> round keys 0..5 as 24 bytes
   function automatic void expand_key(input logic [127:0] mk, output logic [7:0] img [24]);
      logic [31:0] k [10];
      logic [31:0] rk;
      k[0] = mk[127:96] ^ Fk0;
      k[1] = mk[95:64] ^ Fk1;
      k[2] = mk[63:32] ^ Fk2;
      k[3] = mk[31:0] ^ Fk3;
      for (int i = 0; i < 6; i++) begin
         rk = k[i] ^ tau_lprime(k[i+1] ^ k[i+2] ^ k[i+3] ^ ck_word(i));
         k[i+4] = rk;
         for (int j = 0; j < 4; j++) img[4*i+j] = rk[8*j +: 8];
      end
   endfunction

   task automatic add_row(input logic [7:0] d, input bit f, input logic [63:0] b);
      plan.push_back('{data: d, first: f, base: b});
      plan_has_exp.push_back(0);
      plan_exp.push_back('0);
   endtask

   // a key image; the typed-in answer is the key itself
   task automatic add_key_image(input logic [127:0] mk, input bit f, input logic [63:0] b,
                                input bit typed, input logic [63:0] addr);
      logic [7:0] img [24];
      expand_key(mk, img);
      for (int i = 0; i < 24; i++) add_row(img[i], f && i == 0, b);
      if (typed) begin
         plan_has_exp[$] = 1;
         plan_exp[$] = '{addr: addr, k0: mk[127:96], k1: mk[95:64], k2: mk[63:32],
                         k3: mk[31:0]};
      end
   endtask

   // send one byte: random gap, then hold push until accepted; push stays high
   // on return so that a gapless next byte follows without a second drive
   task automatic send_byte(input scan_byte_type it);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= it.data;
      req_starts_buffer <= it.first;
      req_base_address <= it.base;
      do @(posedge clock); while (full);
   endtask

   // Result side: pop drawn per item, compare on each accepted result.
   int pop_wait = 0;
   always @(posedge clock) begin
      key_hit_type got, want;
      if (!reset) begin
         if (pop && !empty) begin
            got = '{addr: rsp_hit_address, k0: rsp_key_word_zero, k1: rsp_key_word_one,
                    k2: rsp_key_word_two, k3: rsp_key_word_three};
            if (pending_keys.size() == 0) begin
               $error("unexpected result addr=%h", got.addr);
               fail_count++;
            end else begin
               want = pending_keys.pop_front();
               if (got.addr != want.addr) begin
                  $error("hit_address exp %h got %h", want.addr, got.addr); fail_count++;
               end
               if (got.k0 != want.k0) begin
                  $error("key_word_zero exp %h got %h", want.k0, got.k0); fail_count++;
               end
               if (got.k1 != want.k1) begin
                  $error("key_word_one exp %h got %h", want.k1, got.k1); fail_count++;
               end
               if (got.k2 != want.k2) begin
                  $error("key_word_two exp %h got %h", want.k2, got.k2); fail_count++;
               end
               if (got.k3 != want.k3) begin
                  $error("key_word_three exp %h got %h", want.k3, got.k3); fail_count++;
               end
            end
            pop_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
         // pop is set exactly once per step
         if (pop_wait > 0) begin
            pop <= 1'b0;
            pop_wait--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no accepted item on either side
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      key_hit_type hit;
      scan_byte_type it;
      logic [127:0] mk;
      logic [63:0] base;
      int drain;

      foreach (win[i]) win[i] = '0;
      win_fill = 0;
      skip_left = 0;
      buf_offset = '0;
      buf_base = '0;

      // Directed: stream before any buffer start (base 0), extremes of key and address,
      // short buffer, address wrap, dropped skip on buffer start.
      add_key_image('0, 0, '0, 1, 64'h0);
      add_key_image({128{1'b1}}, 1, 64'hffff_ffff_ffff_fff0, 1, 64'hffff_ffff_ffff_fff0);
      add_row(8'hff, 1, 64'h5555_aaaa_5555_aaaa);
      add_row(8'h00, 0, '0);
      // the second key image above follows the first inside a new buffer: pending skip is dropped
      foreach (plan[i]) begin
         if (plan_has_exp[i]) begin
            if (!scan_step(plan[i], hit) || hit != plan_exp[i]) begin
               $error("directed row %0d: typed-in key disagrees with predictor", i);
               fail_count++;
            end
            pending_keys.push_back(plan_exp[i]);
         end else if (scan_step(plan[i], hit)) begin
            pending_keys.push_back(hit);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) send_byte(plan[i]);

      // Random: mostly key images in random padding, some buffer starts.
      for (int n = 0; n < 2000; ) begin
         if (n > 1000 && n < 1100) begin
            // hold-off: let every expected result arrive
            push <= 1'b0;
            wait (pending_keys.size() == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 2) != 0) begin
            logic [7:0] img [24];
            mk = {$urandom, $urandom, $urandom, $urandom};
            expand_key(mk, img);
            for (int i = 0; i < 24; i++) begin
               it = '{data: img[i], first: 0, base: '0};
               if (i == 0 && $urandom_range(0, 5) == 0) begin
                  it.first = 1;
                  it.base = {$urandom, $urandom};
               end
               if (scan_step(it, hit)) pending_keys.push_back(hit);
               send_byte(it);
               n++;
            end
         end else begin
            repeat ($urandom_range(1, 30)) begin
               base = {$urandom, $urandom};
               it = '{data: 8'($urandom), first: $urandom_range(0, 15) == 0, base: base};
               if (scan_step(it, hit)) pending_keys.push_back(hit);
               send_byte(it);
               n++;
            end
         end
      end
      push <= 1'b0;
      stim_done = 1;

      wait (pending_keys.size() == 0);
      drain = 0;
      while (drain < DrainCycles) begin
         @(posedge clock);
         drain++;
      end
      if (fail_count == 0 && pending_keys.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
